// File: rtl/pl0ts_pkg.sv
package pl0ts_pkg;

  // character classes handed from the front to the back
  typedef enum logic [3:0] {
    CLS_ALPHA,
    CLS_DIGIT,
    CLS_UNDERSCORE,
    CLS_BLANK,
    CLS_NEWLINE,
    CLS_LBRACE,
    CLS_RBRACE,
    CLS_COLON,
    CLS_PUNCT,
    CLS_OTHER
  } char_cls_e;

  typedef struct packed {
    logic      eot;
    char_cls_e cls;
    logic [4:0] punct_kind;
    logic [7:0] chr;
  } scan_item_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [62:0] num;
    logic [63:0] text;
    logic [7:0]  len;
    logic [31:0] line;
    logic [2:0]  err;
    logic [7:0]  bad;
  } token_t;

  // token kinds
  localparam logic [4:0] KIND_END     = 5'd0;
  localparam logic [4:0] KIND_IDENT   = 5'd1;
  localparam logic [4:0] KIND_NUMBER  = 5'd2;
  localparam logic [4:0] KIND_KW_BASE = 5'd3;
  localparam logic [4:0] KIND_PERIOD  = 5'd14;
  localparam logic [4:0] KIND_EQUAL   = 5'd15;
  localparam logic [4:0] KIND_COMMA   = 5'd16;
  localparam logic [4:0] KIND_SEMI    = 5'd17;
  localparam logic [4:0] KIND_HASH    = 5'd18;
  localparam logic [4:0] KIND_LESS    = 5'd19;
  localparam logic [4:0] KIND_GREATER = 5'd20;
  localparam logic [4:0] KIND_PLUS    = 5'd21;
  localparam logic [4:0] KIND_MINUS   = 5'd22;
  localparam logic [4:0] KIND_STAR    = 5'd23;
  localparam logic [4:0] KIND_SLASH   = 5'd24;
  localparam logic [4:0] KIND_LPAREN  = 5'd25;
  localparam logic [4:0] KIND_RPAREN  = 5'd26;
  localparam logic [4:0] KIND_ASSIGN  = 5'd27;
  localparam logic [4:0] KIND_ERROR   = 5'd28;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_UNKNOWN   = 3'd1;
  localparam logic [2:0] ERR_COLON     = 3'd2;
  localparam logic [2:0] ERR_COMMENT   = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd4;

  localparam logic [62:0] NUM_MAX  = '1;
  localparam logic [31:0] LINE_MAX = '1;
  localparam logic [7:0]  LEN_MAX  = '1;

  // keywords, right-justified strings, first char in the highest used byte
  localparam int unsigned NUM_KW = 11;
  localparam logic [71:0] KW_TEXT [NUM_KW] = '{
    72'("CONST"), 72'("VAR"), 72'("PROCEDURE"), 72'("CALL"), 72'("BEGIN"),
    72'("END"), 72'("IF"), 72'("THEN"), 72'("WHILE"), 72'("DO"), 72'("ODD")
  };
  localparam int unsigned KW_LEN [NUM_KW] = '{5, 3, 9, 4, 5, 3, 2, 4, 5, 2, 3};

  // byte idx of keyword k, 0 beyond its end (never a word character)
  function automatic logic [7:0] kw_char(input int unsigned k, input logic [7:0] idx);
    int unsigned sh;
    logic [71:0] shifted;
    if (32'(idx) >= KW_LEN[k]) begin
      return 8'h00;
    end
    sh = (KW_LEN[k] - 1 - 32'(idx)) * 8;
    shifted = KW_TEXT[k] >> sh;
    return shifted[7:0];
  endfunction

endpackage

// File: rtl/pl0ts_front.sv
module pl0ts_front
  import pl0ts_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_char_i,
  input  logic       in_end_i,
  output logic       out_valid_o,
  output scan_item_t out_item_o,
  input  logic       pop_i
);

  scan_item_t item;
  scan_item_t items_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;

  // classify the byte
  always_comb begin
    item.eot        = in_end_i;
    item.chr        = in_char_i;
    item.punct_kind = KIND_END;
    item.cls        = CLS_OTHER;
    if ((in_char_i >= "A" && in_char_i <= "Z") || (in_char_i >= "a" && in_char_i <= "z")) begin
      item.cls = CLS_ALPHA;
    end else if (in_char_i >= "0" && in_char_i <= "9") begin
      item.cls = CLS_DIGIT;
    end else begin
      unique case (in_char_i)
        "_":   item.cls = CLS_UNDERSCORE;
        " ", 8'h09: item.cls = CLS_BLANK;
        8'h0a: item.cls = CLS_NEWLINE;
        "{":   item.cls = CLS_LBRACE;
        "}":   item.cls = CLS_RBRACE;
        ":":   item.cls = CLS_COLON;
        ".": begin item.cls = CLS_PUNCT; item.punct_kind = KIND_PERIOD;  end
        "=": begin item.cls = CLS_PUNCT; item.punct_kind = KIND_EQUAL;   end
        ",": begin item.cls = CLS_PUNCT; item.punct_kind = KIND_COMMA;   end
        ";": begin item.cls = CLS_PUNCT; item.punct_kind = KIND_SEMI;    end
        "#": begin item.cls = CLS_PUNCT; item.punct_kind = KIND_HASH;    end
        "<": begin item.cls = CLS_PUNCT; item.punct_kind = KIND_LESS;    end
        ">": begin item.cls = CLS_PUNCT; item.punct_kind = KIND_GREATER; end
        "+": begin item.cls = CLS_PUNCT; item.punct_kind = KIND_PLUS;    end
        "-": begin item.cls = CLS_PUNCT; item.punct_kind = KIND_MINUS;   end
        "*": begin item.cls = CLS_PUNCT; item.punct_kind = KIND_STAR;    end
        "/": begin item.cls = CLS_PUNCT; item.punct_kind = KIND_SLASH;   end
        "(": begin item.cls = CLS_PUNCT; item.punct_kind = KIND_LPAREN;  end
        ")": begin item.cls = CLS_PUNCT; item.punct_kind = KIND_RPAREN;  end
        default: item.cls = CLS_OTHER;
      endcase
    end
  end

  // two-entry queue towards the back
  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i & in_ready_o;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_item_o  = items_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) items_q[wr_ptr_q] <= item;
  end

endmodule

// File: rtl/pl0ts_back.sv
module pl0ts_back
  import pl0ts_pkg::*;
#(
  parameter int unsigned IDENT_CHARS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  scan_item_t in_item_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output token_t     out_tok_o,
  output logic       out_last_o
);

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_IDENT   = 3'd1;
  localparam logic [2:0] MODE_NUMBER  = 3'd2;
  localparam logic [2:0] MODE_COLON   = 3'd3;
  localparam logic [2:0] MODE_COMMENT = 3'd4;

  logic [2:0]  mode_q, mode_d;
  logic [62:0] acc_q, acc_d;
  logic        frozen_q, frozen_d;
  logic        ovf_q, ovf_d;
  logic [IDENT_CHARS-1:0][7:0] ibuf_q, ibuf_d;
  logic [7:0]  icnt_q, icnt_d;
  logic [NUM_KW-1:0] alive_q, alive_d;
  logic [31:0] line_q, line_d;

  logic out_valid_q, out_last_q, pend_valid_q;
  token_t out_tok_q, pend_tok_q;

  logic [7:0] c;
  logic is_word, is_numch, id_cont, num_cont;
  logic [IDENT_CHARS-1:0][7:0] ib, ibuf_add;
  logic [7:0] ic, icnt_add;
  logic [NUM_KW-1:0] ia, alive_add;
  logic [62:0] nacc, acc_add;
  logic nfz, nov, frozen_add, ovf_add;
  logic [3:0] digit;
  logic [66:0] wide;
  token_t blank, id_tok, num_tok, p_tok, s_tok;
  logic p_v, s_v, do_idle, found;
  logic take, out_free;

  assign c        = in_item_i.chr;
  assign is_word  = (in_item_i.cls == CLS_ALPHA) || (in_item_i.cls == CLS_DIGIT) ||
                    (in_item_i.cls == CLS_UNDERSCORE);
  assign is_numch = (in_item_i.cls == CLS_DIGIT) || (in_item_i.cls == CLS_UNDERSCORE);
  assign id_cont  = (mode_q == MODE_IDENT) && !in_item_i.eot && is_word;
  assign num_cont = (mode_q == MODE_NUMBER) && !in_item_i.eot && is_numch;

  // identifier append, on the running word or on a fresh one
  always_comb begin
    ib = id_cont ? ibuf_q : '0;
    ic = id_cont ? icnt_q : 8'd0;
    ia = id_cont ? alive_q : '1;
    for (int i = 0; i < IDENT_CHARS; i++) begin
      ibuf_add[i] = (ic == 8'(i)) ? c : ib[i];
    end
    for (int k = 0; k < NUM_KW; k++) begin
      alive_add[k] = ia[k] & (kw_char(k, ic) == c);
    end
    icnt_add = (ic == LEN_MAX) ? ic : ic + 8'd1;
  end

  // decimal append: value*10 + digit checked against the 63-bit limit
  always_comb begin
    nacc       = num_cont ? acc_q : '0;
    nfz        = num_cont ? frozen_q : 1'b0;
    nov        = num_cont ? ovf_q : 1'b0;
    digit      = 4'(c - "0");
    wide       = ({4'b0, nacc} << 3) + ({4'b0, nacc} << 1) + 67'(digit);
    acc_add    = nacc;
    frozen_add = nfz;
    ovf_add    = nov;
    if (in_item_i.cls == CLS_UNDERSCORE) begin
      frozen_add = 1'b1;
    end else if (!nfz && !nov) begin
      if (wide > 67'(NUM_MAX)) begin
        ovf_add = 1'b1;
        acc_add = NUM_MAX;
      end else begin
        acc_add = wide[62:0];
      end
    end
  end

  // finished tokens
  always_comb begin
    blank      = '0;
    blank.line = line_q;
    id_tok      = blank;
    id_tok.kind = KIND_IDENT;
    id_tok.text = 64'(ibuf_q);
    id_tok.len  = icnt_q;
    found = 1'b0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (!found && alive_q[k] && icnt_q == 8'(KW_LEN[k])) begin
        found       = 1'b1;
        id_tok.kind = KIND_KW_BASE + 5'(k);
      end
    end
    num_tok = blank;
    if (ovf_q) begin
      num_tok.kind = KIND_ERROR;
      num_tok.num  = NUM_MAX;
      num_tok.err  = ERR_OVERFLOW;
    end else begin
      num_tok.kind = KIND_NUMBER;
      num_tok.num  = acc_q;
    end
  end

  // scanner step
  always_comb begin
    mode_d   = mode_q;
    acc_d    = acc_q;
    frozen_d = frozen_q;
    ovf_d    = ovf_q;
    ibuf_d   = ibuf_q;
    icnt_d   = icnt_q;
    alive_d  = alive_q;
    line_d   = line_q;
    p_v      = 1'b0;
    s_v      = 1'b0;
    p_tok    = blank;
    s_tok    = blank;
    do_idle  = 1'b0;

    if (in_item_i.eot) begin
      mode_d = MODE_IDLE;
      s_v    = 1'b1;
      unique case (mode_q)
        MODE_IDENT:  begin p_v = 1'b1; p_tok = id_tok; end
        MODE_NUMBER: begin p_v = 1'b1; p_tok = num_tok; end
        MODE_COLON: begin
          p_v = 1'b1; p_tok.kind = KIND_ERROR; p_tok.err = ERR_COLON;
        end
        MODE_COMMENT: begin
          p_v = 1'b1; p_tok.kind = KIND_ERROR; p_tok.err = ERR_COMMENT;
        end
        default: p_v = 1'b0;
      endcase
    end else begin
      unique case (mode_q)
        MODE_IDENT: begin
          if (is_word) begin
            ibuf_d = ibuf_add; icnt_d = icnt_add; alive_d = alive_add;
          end else begin
            p_v = 1'b1; p_tok = id_tok; do_idle = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (is_numch) begin
            acc_d = acc_add; frozen_d = frozen_add; ovf_d = ovf_add;
          end else begin
            p_v = 1'b1; p_tok = num_tok; do_idle = 1'b1;
          end
        end
        MODE_COLON: begin
          p_v    = 1'b1;
          mode_d = MODE_IDLE;
          if (in_item_i.cls == CLS_PUNCT && in_item_i.punct_kind == KIND_EQUAL) begin
            p_tok.kind = KIND_ASSIGN;
          end else begin
            p_tok.kind = KIND_ERROR; p_tok.err = ERR_COLON; p_tok.bad = c;
            do_idle = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (in_item_i.cls == CLS_RBRACE) begin
            mode_d = MODE_IDLE;
          end else if (in_item_i.cls == CLS_NEWLINE && line_q != LINE_MAX) begin
            line_d = line_q + 32'd1;
          end
        end
        default: do_idle = 1'b1;
      endcase

      if (do_idle) begin
        mode_d = MODE_IDLE;
        unique case (in_item_i.cls)
          CLS_BLANK: mode_d = MODE_IDLE;
          CLS_NEWLINE: begin
            if (line_q != LINE_MAX) line_d = line_q + 32'd1;
          end
          CLS_ALPHA, CLS_UNDERSCORE: begin
            mode_d = MODE_IDENT;
            ibuf_d = ibuf_add; icnt_d = icnt_add; alive_d = alive_add;
          end
          CLS_DIGIT: begin
            mode_d = MODE_NUMBER;
            acc_d = acc_add; frozen_d = frozen_add; ovf_d = ovf_add;
          end
          CLS_LBRACE: mode_d = MODE_COMMENT;
          CLS_COLON:  mode_d = MODE_COLON;
          CLS_PUNCT: begin
            s_v = 1'b1; s_tok.kind = in_item_i.punct_kind;
          end
          CLS_RBRACE, CLS_OTHER: begin
            s_v = 1'b1; s_tok.kind = KIND_ERROR; s_tok.err = ERR_UNKNOWN; s_tok.bad = c;
          end
          default: mode_d = MODE_IDLE;
        endcase
      end
    end
  end

  // the back takes an item only with no second token waiting
  assign out_free = !out_valid_q || out_ready_i;
  assign take     = !pend_valid_q && out_free;
  assign pop_o    = in_valid_i && take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_IDLE;
      acc_q        <= '0;
      frozen_q     <= 1'b0;
      ovf_q        <= 1'b0;
      ibuf_q       <= '0;
      icnt_q       <= 8'd0;
      alive_q      <= '1;
      line_q       <= 32'd0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        mode_q   <= mode_d;
        acc_q    <= acc_d;
        frozen_q <= frozen_d;
        ovf_q    <= ovf_d;
        ibuf_q   <= ibuf_d;
        icnt_q   <= icnt_d;
        alive_q  <= alive_d;
        line_q   <= line_d;
      end
      if (out_free) begin
        if (pend_valid_q) begin
          out_valid_q  <= 1'b1;
          pend_valid_q <= 1'b0;
        end else if (pop_o) begin
          out_valid_q  <= p_v || s_v;
          pend_valid_q <= p_v && s_v;
        end else begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (pend_valid_q) begin
        out_tok_q  <= pend_tok_q;
        out_last_q <= 1'b1;
      end else if (pop_o) begin
        out_tok_q  <= p_v ? p_tok : s_tok;
        out_last_q <= !(p_v && s_v);
        pend_tok_q <= s_tok;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_tok_o   = out_tok_q;
  assign out_last_o  = out_last_q;

endmodule

// File: rtl/pl0_token_scanner.sv
// PL/0 token scanner.
// Input stream: one source byte per word on s_axis (tdata = char code),
// tuser set marks end of text instead of a byte. Output stream: one token
// per word on m_axis, tuser = token kind, tlast on the last token that an
// input word produced. An end-of-text word flushes any pending token and
// always yields an end token.
// Front classifies each byte and parks it in a two-entry queue; the back
// runs the scanner state and owns the output register plus one holding
// slot for a second token.
// Path: the byte completing a token is queued by the front, popped by the back
// and the token registered in the back's output register, once that is free.
// Throughput: 1 word per cycle while words yield at most one token and m_axis
// accepts tokens; a word yielding two tokens holds the back until its second
// token leaves the holding slot, bounded by the single output port.
// Reset: scanner idle, line count 0, queue and output empty.
// Output stall: the back stops, the queue fills within two words and then
// s_axis_tready_o drops; nothing is lost or repeated.
module pl0_token_scanner
  import pl0ts_pkg::*;
#(
  parameter int unsigned IDENT_CHARS = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // char_code[7:0]
  input  logic         s_axis_tuser_i,   // end_of_text
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // number_value[62:0], ident_text[126:63], ident_length[134:127],
  // line_number[166:135], error_code[169:167], bad_char[177:170], zeros
  output logic [183:0] m_axis_tdata_o,
  output logic [4:0]   m_axis_tuser_o,   // token_kind
  output logic         m_axis_tlast_o
);

  scan_item_t q_item;
  logic       q_valid, q_pop;
  token_t     tok;

  pl0ts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_char_i   (s_axis_tdata_i),
    .in_end_i    (s_axis_tuser_i),
    .out_valid_o (q_valid),
    .out_item_o  (q_item),
    .pop_i       (q_pop)
  );

  pl0ts_back #(
    .IDENT_CHARS (IDENT_CHARS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_item_i   (q_item),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_tok_o   (tok),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tuser_o = tok.kind;
  assign m_axis_tdata_o = {6'b0, tok.bad, tok.err, tok.line, tok.len, tok.text, tok.num};

  // end token always closes its word's run
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == KIND_END) |-> m_axis_tlast_o)
    else $error("end token without tlast");

  // error code present exactly on error tokens
  a_err_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((m_axis_tuser_o == KIND_ERROR) == (tok.err != ERR_NONE)))
    else $error("error code and token kind disagree");

  // back never pops an empty queue
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

// File: verif/pl0_token_scanner_chk.sv
module pl0_token_scanner_chk
  import pl0ts_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  input  logic         s_axis_tready_i,
  input  logic [7:0]   s_axis_tdata_i,
  input  logic         s_axis_tuser_i,
  input  logic         m_axis_tvalid_i,
  input  logic         m_axis_tready_i,
  input  logic [183:0] m_axis_tdata_i,
  input  logic [4:0]   m_axis_tuser_i,
  input  logic         m_axis_tlast_i,
  output int           mismatches_o,
  output int           tokens_due_o,
  output int           tokens_seen_o,
  output logic [31:0]  kinds_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          TEXT_BYTES = 8;
  localparam int          HEAD_BYTES = 9;   // longest keyword
  localparam logic [63:0] VALUE_CAP  = {1'b0, NUM_MAX};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WORD,
    ST_NUMBER,
    ST_COLON,
    ST_REMARK
  } scan_state_e;

  typedef struct packed {
    token_t tok;
    logic   last;
  } due_token_t;

  due_token_t  due_q[$];
  token_t      step_q[$];
  due_token_t  oldest;

  scan_state_e scan_state;
  logic [63:0] num_acc;
  logic        num_frozen;
  logic        num_over;
  logic [63:0] word_text;
  logic [7:0]  word_len;
  logic [7:0]  word_head [HEAD_BYTES];
  logic [31:0] line_cnt;
  logic [31:0] step_line;

  function automatic string keyword_name(input int k);
    case (k)
      0:       return "CONST";
      1:       return "VAR";
      2:       return "PROCEDURE";
      3:       return "CALL";
      4:       return "BEGIN";
      5:       return "END";
      6:       return "IF";
      7:       return "THEN";
      8:       return "WHILE";
      9:       return "DO";
      10:      return "ODD";
      default: return "";
    endcase
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  task automatic emit_token(input logic [4:0] kind, input logic [62:0] num,
                            input logic [63:0] text, input logic [7:0] len,
                            input logic [2:0] err, input logic [7:0] bad);
    token_t t;
    t.kind = kind;
    t.num  = num;
    t.text = text;
    t.len  = len;
    t.line = step_line;
    t.err  = err;
    t.bad  = bad;
    step_q.insert(step_q.size(), t);
  endtask

  task automatic count_newline();
    if (line_cnt != LINE_MAX) line_cnt = line_cnt + 32'd1;
  endtask

  task automatic word_append(input logic [7:0] c);
    if (int'(word_len) < TEXT_BYTES) word_text[8*int'(word_len) +: 8] = c;
    if (int'(word_len) < HEAD_BYTES) word_head[word_len] = c;
    if (word_len != LEN_MAX) word_len = word_len + 8'd1;
  endtask

  // keyword only on full-length match
  task automatic word_close();
    logic [4:0] kind;
    string      kw;
    logic       hit;
    kind = KIND_IDENT;
    for (int k = 0; k < 11; k++) begin
      kw = keyword_name(k);
      if (kind == KIND_IDENT && int'(word_len) == kw.len()) begin
        hit = 1'b1;
        for (int i = 0; i < kw.len(); i++) begin
          if (word_head[i] != kw[i]) hit = 1'b0;
        end
        if (hit) kind = KIND_KW_BASE + 5'(k);
      end
    end
    emit_token(kind, '0, word_text, word_len, ERR_NONE, 8'h00);
    word_text  = '0;
    word_len   = '0;
    scan_state = ST_IDLE;
  endtask

  task automatic num_append(input logic [7:0] c);
    logic [63:0] d;
    if (c == "_") begin
      num_frozen = 1'b1;
    end else if (!num_frozen && !num_over) begin
      d = 64'(c - 8'h30);
      if (num_acc > (VALUE_CAP - d) / 64'd10) begin
        num_over = 1'b1;
        num_acc  = VALUE_CAP;
      end else begin
        num_acc = num_acc * 64'd10 + d;
      end
    end
  endtask

  task automatic num_close();
    if (num_over) emit_token(KIND_ERROR, NUM_MAX, '0, '0, ERR_OVERFLOW, 8'h00);
    else          emit_token(KIND_NUMBER, num_acc[62:0], '0, '0, ERR_NONE, 8'h00);
    num_acc    = '0;
    num_frozen = 1'b0;
    num_over   = 1'b0;
    scan_state = ST_IDLE;
  endtask

  // character seen between tokens
  task automatic scan_fresh(input logic [7:0] c);
    logic [4:0] kind;
    kind       = KIND_ERROR;
    scan_state = ST_IDLE;
    if (is_letter(c) || c == "_") begin
      word_text = '0;
      word_len  = '0;
      word_append(c);
      scan_state = ST_WORD;
    end else if (is_digit(c)) begin
      num_acc    = '0;
      num_frozen = 1'b0;
      num_over   = 1'b0;
      num_append(c);
      scan_state = ST_NUMBER;
    end else begin
      case (c)
        " ", "\t": ;
        "\n":      count_newline();
        "{":       scan_state = ST_REMARK;
        ":":       scan_state = ST_COLON;
        ".":       kind = KIND_PERIOD;
        "=":       kind = KIND_EQUAL;
        ",":       kind = KIND_COMMA;
        ";":       kind = KIND_SEMI;
        "#":       kind = KIND_HASH;
        "<":       kind = KIND_LESS;
        ">":       kind = KIND_GREATER;
        "+":       kind = KIND_PLUS;
        "-":       kind = KIND_MINUS;
        "*":       kind = KIND_STAR;
        "/":       kind = KIND_SLASH;
        "(":       kind = KIND_LPAREN;
        ")":       kind = KIND_RPAREN;
        default:   emit_token(KIND_ERROR, '0, '0, '0, ERR_UNKNOWN, c);
      endcase
      if (kind != KIND_ERROR) emit_token(kind, '0, '0, '0, ERR_NONE, 8'h00);
    end
  endtask

  task automatic predict_tokens(input logic [7:0] c, input logic eot);
    due_token_t d;
    step_line = line_cnt;
    step_q.delete();
    if (eot) begin
      case (scan_state)
        ST_WORD:   word_close();
        ST_NUMBER: num_close();
        ST_COLON:  emit_token(KIND_ERROR, '0, '0, '0, ERR_COLON, 8'h00);
        ST_REMARK: emit_token(KIND_ERROR, '0, '0, '0, ERR_COMMENT, 8'h00);
        default: ;
      endcase
      scan_state = ST_IDLE;
      emit_token(KIND_END, '0, '0, '0, ERR_NONE, 8'h00);
    end else begin
      case (scan_state)
        ST_WORD: begin
          if (is_letter(c) || is_digit(c) || c == "_") begin
            word_append(c);
          end else begin
            word_close();
            scan_fresh(c);
          end
        end
        ST_NUMBER: begin
          if (is_digit(c) || c == "_") begin
            num_append(c);
          end else begin
            num_close();
            scan_fresh(c);
          end
        end
        ST_COLON: begin
          scan_state = ST_IDLE;
          if (c == "=") begin
            emit_token(KIND_ASSIGN, '0, '0, '0, ERR_NONE, 8'h00);
          end else begin
            emit_token(KIND_ERROR, '0, '0, '0, ERR_COLON, c);
            scan_fresh(c);
          end
        end
        ST_REMARK: begin
          if (c == "}") scan_state = ST_IDLE;
          else if (c == "\n") count_newline();
        end
        default: scan_fresh(c);
      endcase
    end
    foreach (step_q[i]) begin
      d.tok  = step_q[i];
      d.last = (i == step_q.size() - 1);
      due_q.insert(due_q.size(), d);
    end
  endtask

  task automatic compare_field(input string what, input logic [63:0] want,
                               input logic [63:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, seen);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      due_q.delete();
      scan_state    = ST_IDLE;
      num_acc       = '0;
      num_frozen    = 1'b0;
      num_over      = 1'b0;
      word_text     = '0;
      word_len      = '0;
      line_cnt      = '0;
      mismatches_o  = 0;
      tokens_due_o  = 0;
      tokens_seen_o = 0;
      kinds_seen_o  = '0;
    end else begin
      // token out first: it always stems from an older word
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        tokens_seen_o++;
        kinds_seen_o[m_axis_tuser_i] = 1'b1;
        if (due_q.size() == 0) begin
          $display("%0t: token with none due, expected nothing, got kind %0d",
                   $time, m_axis_tuser_i);
          mismatches_o++;
        end else begin
          oldest = due_q.pop_front();
          compare_field("token_kind", oldest.tok.kind, m_axis_tuser_i);
          compare_field("number_value", oldest.tok.num, m_axis_tdata_i[62:0]);
          compare_field("ident_text", oldest.tok.text, m_axis_tdata_i[126:63]);
          compare_field("ident_length", oldest.tok.len, m_axis_tdata_i[134:127]);
          compare_field("line_number", oldest.tok.line, m_axis_tdata_i[166:135]);
          compare_field("error_code", oldest.tok.err, m_axis_tdata_i[169:167]);
          compare_field("bad_char", oldest.tok.bad, m_axis_tdata_i[177:170]);
          compare_field("pad", '0, m_axis_tdata_i[183:178]);
          compare_field("last_of_run", oldest.last, m_axis_tlast_i);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        predict_tokens(s_axis_tdata_i, s_axis_tuser_i);
      end
      tokens_due_o = due_q.size();
    end
  end

endmodule

// File: verif/pl0_token_scanner_tb.sv
module pl0_token_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_WORDS = 1350;   // random words after the directed opening
  localparam int LONG_HOLD    = 400;    // cycles the sink sits on tready once
  localparam int DRAIN_CYCLES = 30;

  // bit 8 marks end of text, bits 7:0 the character
  typedef logic [8:0] src_word_t;

  logic         clk;
  logic         rst_n;
  logic         s_tvalid;
  logic         s_tready;
  logic [7:0]   s_tdata;
  logic         s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [183:0] m_tdata;
  logic [4:0]   m_tuser;
  logic         m_tlast;

  int           mismatches;
  int           tokens_due;
  int           tokens_seen;
  logic [31:0]  kinds_seen;

  src_word_t    frag[$];      // words waiting to go out
  int           useful;       // words that count towards the random budget
  int           words_sent;
  int           ends_sent;
  int           long_words;
  int           cycles;
  logic         snd_calm;
  logic         rcv_calm;
  logic         long_hold;    // sender asks, sink clears once its hold is over
  logic         hold_done;

  pl0_token_scanner DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  pl0_token_scanner_chk scan_chk (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .m_axis_tlast_i  (m_tlast),
    .mismatches_o    (mismatches),
    .tokens_due_o    (tokens_due),
    .tokens_seen_o   (tokens_seen),
    .kinds_seen_o    (kinds_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake or a lost token ends up here
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // word source helpers
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] word_chr(input int r);  // r in 0..62
    if (r < 26) return 8'h41 + 8'(r);
    if (r < 52) return 8'h61 + 8'(r - 26);
    if (r < 62) return 8'h30 + 8'(r - 52);
    return 8'h5F;
  endfunction

  task automatic push_chr(input logic [7:0] c);
    frag.insert(frag.size(), {1'b0, c});
  endtask

  task automatic push_end(input logic [7:0] c);
    frag.insert(frag.size(), {1'b1, c});
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_chr(s[i]);
  endtask

  task automatic push_keyword(input int k);
    case (k)
      0:       push_str("CONST");
      1:       push_str("VAR");
      2:       push_str("PROCEDURE");
      3:       push_str("CALL");
      4:       push_str("BEGIN");
      5:       push_str("END");
      6:       push_str("IF");
      7:       push_str("THEN");
      8:       push_str("WHILE");
      9:       push_str("DO");
      default: push_str("ODD");
    endcase
  endtask

  // One word on s_axis. Entered and left at a falling edge; tvalid is only
  // dropped when a gap is drawn, so back-to-back words keep it high.
  task automatic send_word(input logic [7:0] c, input logic eot);
    int gap;
    if ($urandom_range(0, 63) == 0) snd_calm = !snd_calm;
    if (snd_calm || long_hold)            gap = 0;
    else if ($urandom_range(0, 3) == 0)   gap = $urandom_range(0, 17);
    else                                  gap = $urandom_range(0, 2);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tuser  <= eot;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    words_sent++;
    if (eot) ends_sent++;
  endtask

  task automatic send_frag();
    foreach (frag[i]) send_word(frag[i][7:0], frag[i][8]);
    frag.delete();
  endtask

  // One random lexical fragment plus an optional separator. Mostly sensible
  // source text so identifiers, numbers and comments run their full course;
  // the rest is noise, stray braces, broken colons and early end markers.
  task automatic make_fragment();
    int    pick;
    int    n;
    int    r;
    int    start;
    string ops;
    ops   = ".=,;#<>+-*/()";
    start = frag.size();
    pick  = $urandom_range(0, 99);
    if (pick < 15) begin
      // keyword, sometimes spoilt into an identifier
      push_keyword($urandom_range(0, 10));
      case ($urandom_range(0, 7))
        0:       push_chr(word_chr($urandom_range(0, 62)));
        1:       void'(frag.pop_back());
        2:       frag[start] = frag[start] | 9'h020;
        default: ;
      endcase
    end else if (pick < 30) begin
      // identifier; a handful run past the 255 length saturation
      if (long_words < 3 && $urandom_range(0, 149) == 0) begin
        n = $urandom_range(250, 270);
        long_words++;
      end else begin
        n = $urandom_range(1, 12);
      end
      r = $urandom_range(0, 52);
      push_chr(word_chr(r == 52 ? 62 : r));
      repeat (n - 1) push_chr(word_chr($urandom_range(0, 62)));
    end else if (pick < 45) begin
      // number, now and then long enough to overflow or with an underscore
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(19, 24) : $urandom_range(1, 18);
      r = ($urandom_range(0, 4) == 0) ? $urandom_range(1, n) : 0;
      for (int i = 0; i < n; i++) begin
        if (r != 0 && i == r) push_chr("_");
        push_chr(8'h30 + 8'($urandom_range(0, 9)));
      end
      if (r != 0 && r == n) push_chr("_");
    end else if (pick < 65) begin
      if ($urandom_range(0, 13) == 0) push_str(":=");
      else                            push_chr(ops[$urandom_range(0, 12)]);
    end else if (pick < 73) begin
      // colon followed by anything
      push_chr(":");
      push_chr(8'($urandom_range(0, 255)));
    end else if (pick < 81) begin
      // comment with inner opening braces and newlines
      push_chr("{");
      repeat ($urandom_range(0, 10)) begin
        r = $urandom_range(0, 5);
        if (r == 0)      push_chr("{");
        else if (r == 1) push_chr("\n");
        else begin
          n = $urandom_range(0, 255);
          push_chr(n == 8'h7D ? 8'h78 : 8'(n));
        end
      end
      push_chr("}");
    end else if (pick < 89) begin
      push_chr(8'($urandom_range(0, 255)));
    end else if (pick < 94) begin
      repeat ($urandom_range(1, 3)) push_chr("\n");
    end else if (pick < 97) begin
      push_end(8'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 2))
        0:       push_chr("}");
        1:       push_chr(8'h0D);
        default: push_chr(8'($urandom_range(128, 255)));
      endcase
    end
    r = $urandom_range(0, 9);
    if (r >= 5 && r <= 7) push_chr(" ");
    else if (r == 8)      push_chr("\t");
    else if (r == 9)      push_chr("\n");
    useful += frag.size() - start;
  endtask

  // ---------------------------------------------------------------------------
  // token sink: random stall per token, plus one long hold to back the block up
  // ---------------------------------------------------------------------------
  initial begin
    int   hold;
    logic was_long;
    m_tready = 1'b0;
    rcv_calm = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) rcv_calm = !rcv_calm;
      was_long = long_hold;
      if (was_long)                       hold = LONG_HOLD;
      else if (rcv_calm)                  hold = 0;
      else if ($urandom_range(0, 3) == 0) hold = $urandom_range(0, 17);
      else                                hold = $urandom_range(0, 2);
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      if (was_long) long_hold = 1'b0;
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and verdict
  // ---------------------------------------------------------------------------
  initial begin
    s_tvalid   = 1'b0;
    s_tdata    = 8'h00;
    s_tuser    = 1'b0;
    rst_n      = 1'b0;
    useful     = 0;
    words_sent = 0;
    ends_sent  = 0;
    long_words = 0;
    snd_calm   = 1'b0;
    long_hold  = 1'b0;
    hold_done  = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: nine-letter keyword, largest number and first overflow,
    // underscore freezing digits, every operator, colon errors (one before a
    // newline), unknown bytes and a stray brace, a comment with an inner brace,
    // then end markers inside a colon, a comment, an identifier, idle and a number
    push_str("PROCEDURE 9223372036854775807;9223372036854775808\n");
    push_str("1_99.=,;#<>+-*/():=:x:\n");
    push_chr(8'h0D);
    push_chr(8'hFF);
    push_chr(8'h00);
    push_str("}{a{b\n}x0_Z:");
    push_end(8'hFF);
    push_str("{");
    push_end(8'h00);
    push_str("ab");
    push_end(8'h41);
    push_end(8'h00);
    push_str("0");
    push_end(8'h7F);
    send_frag();

    // random source text
    while (useful < RANDOM_WORDS) begin
      if (!hold_done && useful >= 500) begin
        long_hold = 1'b1;
        hold_done = 1'b1;
      end
      make_fragment();
      send_frag();
    end
    push_end(8'($urandom_range(0, 255)));
    send_frag();
    s_tvalid <= 1'b0;

    // drain; the watchdog covers a token that never shows
    while (tokens_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Scanned %0d words (%0d end markers); %0d tokens checked over %0d token kinds.",
             words_sent, ends_sent, tokens_seen, $countones(kinds_seen));
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
